FILE: hdl/fpss_pkg.sv
`default_nettype none
package fpss_pkg;

  localparam int ADDR_W       = 24;
  localparam int LEN_W        = 14;
  localparam int CNT_W        = 13;
  localparam int END_W        = ADDR_W + 1;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4 * 1024;
  localparam int MAX_LEN      = 8192;
  localparam int MAX_RESULTS  = 33;

  localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
  localparam int ROOM_W       = PAGE_LOG + 1;
  localparam int RES_W        = $clog2(MAX_RESULTS);

  localparam logic [END_W-1:0]  FLASH_TOP   = END_W'(1) << ADDR_W;
  localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_BYTES - 1);

  // classified request, handed from the front to the back
  typedef struct packed {
    logic              erase;
    logic              zero;
    logic [ADDR_W-1:0] cur;
    logic [END_W-1:0]  range_end;
  } req_t;

endpackage
`default_nettype wire

FILE: hdl/fpss_front.sv
`default_nettype none
module fpss_front (
  input  wire logic                      req_type,
  input  wire logic [fpss_pkg::ADDR_W-1:0] start_addr,
  input  wire logic [fpss_pkg::LEN_W-1:0]  byte_len,
  output fpss_pkg::req_t                 req
);

  logic [fpss_pkg::LEN_W-1:0] len_sat;
  logic [fpss_pkg::END_W-1:0] end_raw;

  always_comb begin
    // saturate length, clip the range at the top of flash, align an erase start to its sector
    if (byte_len > fpss_pkg::LEN_W'(fpss_pkg::MAX_LEN)) begin
      len_sat = fpss_pkg::LEN_W'(fpss_pkg::MAX_LEN);
    end else begin
      len_sat = byte_len;
    end
    end_raw = {1'b0, start_addr} + fpss_pkg::END_W'(len_sat);

    req.erase = req_type;
    req.zero  = (len_sat == '0);
    if (end_raw > fpss_pkg::FLASH_TOP) begin
      req.range_end = fpss_pkg::FLASH_TOP;
    end else begin
      req.range_end = end_raw;
    end
    if (req_type) begin
      req.cur = start_addr & ~fpss_pkg::SECTOR_MASK;
    end else begin
      req.cur = start_addr;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fpss_req_fifo.sv
`default_nettype none
module fpss_req_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire fpss_pkg::req_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output fpss_pkg::req_t rd_data,
  output logic          not_empty
);

  fpss_pkg::req_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (rd_en) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fpss_back.sv
`default_nettype none
module fpss_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_avail,
  input  wire fpss_pkg::req_t              req,
  output logic                             req_take,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [fpss_pkg::ADDR_W-1:0]      op_addr,
  output logic [fpss_pkg::CNT_W-1:0]       byte_count,
  output logic                             last
);

  logic                        active_r;
  logic                        active_nxt;
  logic                        erase_r;
  logic                        zero_r;
  logic [fpss_pkg::ADDR_W-1:0] cur_r;
  logic [fpss_pkg::END_W-1:0]  end_r;
  logic [fpss_pkg::RES_W-1:0]  k_r;
  logic                        out_v_r;
  logic                        out_v_nxt;
  logic [fpss_pkg::ADDR_W-1:0] out_addr_r;
  logic [fpss_pkg::CNT_W-1:0]  out_cnt_r;
  logic                        out_last_r;

  logic                        step;
  logic [fpss_pkg::ROOM_W-1:0] room;
  logic [fpss_pkg::END_W-1:0]  left_full;
  logic [fpss_pkg::LEN_W-1:0]  left;
  logic [fpss_pkg::CNT_W-1:0]  cnt;
  logic [fpss_pkg::END_W-1:0]  next_addr;
  logic                        fin;

  assign req_take   = !active_r && req_avail;
  assign step       = active_r && (!out_v_r || pop);
  assign empty      = !out_v_r;
  assign op_addr    = out_addr_r;
  assign byte_count = out_cnt_r;
  assign last       = out_last_r;

  always_comb begin
    room      = fpss_pkg::ROOM_W'(fpss_pkg::PAGE_BYTES)
              - {1'b0, cur_r[fpss_pkg::PAGE_LOG-1:0]};
    // a write never spans more than the saturated length
    left_full = end_r - {1'b0, cur_r};
    left      = left_full[fpss_pkg::LEN_W-1:0];
    if (zero_r) begin
      cnt = '0;
    end else if (erase_r) begin
      cnt = fpss_pkg::CNT_W'(fpss_pkg::SECTOR_BYTES);
    end else if (fpss_pkg::LEN_W'(room) < left) begin
      cnt = fpss_pkg::CNT_W'(room);
    end else begin
      cnt = fpss_pkg::CNT_W'(left);
    end
    if (erase_r) begin
      next_addr = {1'b0, cur_r} + fpss_pkg::END_W'(fpss_pkg::SECTOR_BYTES);
    end else begin
      next_addr = {1'b0, cur_r} + fpss_pkg::END_W'(cnt);
    end
    fin = zero_r || (next_addr >= end_r)
       || (k_r == fpss_pkg::RES_W'(fpss_pkg::MAX_RESULTS - 1));

    active_nxt = active_r;
    if (req_take) begin
      active_nxt = 1'b1;
    end else if (step && fin) begin
      active_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      erase_r <= req.erase;
      zero_r  <= req.zero;
      cur_r   <= req.cur;
      end_r   <= req.range_end;
      k_r     <= '0;
    end else if (step) begin
      cur_r <= next_addr[fpss_pkg::ADDR_W-1:0];
      k_r   <= k_r + fpss_pkg::RES_W'(1);
    end
    if (step) begin
      out_addr_r <= cur_r;
      out_cnt_r  <= cnt;
      out_last_r <= fin;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/flash_page_and_sector_splitter.sv
// flash page and sector splitter
// input channel: push, full, in_req_type, in_start_addr, in_byte_len; a request
//   is taken on a clock edge with push high and full low
// result channel: empty, pop, out_op_addr, out_byte_count, out_last; the oldest
//   result sits on the out_ ports while empty is low and leaves on pop
// a write is cut into page program chunks that never cross a page boundary; an
//   erase gives one result per touched sector from the sector-aligned start;
//   a zero length request gives one result with a count of 0; out_last marks
//   the final result of every request
// the front classifies requests (length saturation, clipping at the top of
//   flash, sector alignment) into a two entry request queue; the back walks one
//   request at a time and emits one result per cycle into an output register
//   while that register is free or popped; a request passes the queue entry,
//   the walker's request registers and the output register before its first
//   result shows; the walker takes a new request only once the last one is done
// when the receiver stalls the output register holds and the back waits; the
//   queue keeps taking requests until it is full
// reset clears the queue, the walker and the output valid flag
`default_nettype none
module flash_page_and_sector_splitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_req_type,
  input  wire logic [fpss_pkg::ADDR_W-1:0]   in_start_addr,
  input  wire logic [fpss_pkg::LEN_W-1:0]    in_byte_len,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [fpss_pkg::ADDR_W-1:0]        out_op_addr,
  output logic [fpss_pkg::CNT_W-1:0]         out_byte_count,
  output logic                               out_last
);

  fpss_pkg::req_t front_req;
  fpss_pkg::req_t head_req;
  logic           q_full;
  logic           q_not_empty;
  logic           q_take;
  logic           in_accept;

  // a request transaction
  assign in_accept = push && !q_full;
  assign full      = q_full;

  // classify the incoming request
  fpss_front u_front (
    .req_type   (in_req_type),
    .start_addr (in_start_addr),
    .byte_len   (in_byte_len),
    .req        (front_req)
  );

  // short queue between classifier and walker
  fpss_req_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_accept),
    .wr_data   (front_req),
    .full      (q_full),
    .rd_en     (q_take),
    .rd_data   (head_req),
    .not_empty (q_not_empty)
  );

  // walk pages or sectors, one result per cycle while the output is free or popped
  fpss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_avail  (q_not_empty),
    .req        (head_req),
    .req_take   (q_take),
    .empty      (empty),
    .pop        (pop),
    .op_addr    (out_op_addr),
    .byte_count (out_byte_count),
    .last       (out_last)
  );

endmodule
`default_nettype wire

FILE: tb/flash_page_and_sector_splitter_test.sv
`default_nettype none
module flash_page_and_sector_splitter_test;

  // request kinds as carried on in_req_type
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_ERASE = 1'b1;

  // run length guard, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // long receiver hold-off, started twice from its own cycle count
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT_A   = 1500;
  localparam int HOLD_AT_B   = 9000;
  // settle time after the last expected transaction
  localparam int DRAIN_TAIL  = 40;

  typedef struct {
    logic                        erase;
    logic [fpss_pkg::ADDR_W-1:0] start;
    logic [fpss_pkg::LEN_W-1:0]  len;
  } flash_req_t;

  typedef struct packed {
    logic [fpss_pkg::ADDR_W-1:0] op_addr;
    logic [fpss_pkg::CNT_W-1:0]  byte_count;
    logic                        last;
  } chunk_t;

  // receiver stall patterns
  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_SPARSE} drain_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        push = 1'b0;
  logic                        full;
  logic                        in_req_type = 1'b0;
  logic [fpss_pkg::ADDR_W-1:0] in_start_addr = '0;
  logic [fpss_pkg::LEN_W-1:0]  in_byte_len = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [fpss_pkg::ADDR_W-1:0] out_op_addr;
  logic [fpss_pkg::CNT_W-1:0]  out_byte_count;
  logic                        out_last;

  flash_req_t  req_q[$];      // requests waiting to be offered
  chunk_t      chunk_q[$];    // page chunks and sectors still owed by the block
  flash_req_t  offered;       // request currently on the in_ ports
  int          n_total = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  int          n_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          drain_left = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          hold_left = 0;
  int          hold_clock = 0;

  flash_page_and_sector_splitter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_start_addr  (in_start_addr),
    .in_byte_len    (in_byte_len),
    .empty          (empty),
    .pop            (pop),
    .out_op_addr    (out_op_addr),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  // expected split of one accepted request, appended to chunk_q
  function automatic void split_request(flash_req_t req);
    logic [fpss_pkg::LEN_W-1:0] len;
    logic [fpss_pkg::END_W-1:0] stop;
    logic [fpss_pkg::END_W-1:0] addr;
    logic [fpss_pkg::END_W-1:0] nxt;
    logic [fpss_pkg::END_W-1:0] room;
    logic [fpss_pkg::END_W-1:0] left;
    logic [fpss_pkg::CNT_W-1:0] cnt;
    logic                       fin;
    chunk_t                     c;
    int                         k;
    // saturate the length, then clip the range at the top of flash
    len = (req.len > fpss_pkg::MAX_LEN) ? fpss_pkg::LEN_W'(fpss_pkg::MAX_LEN) : req.len;
    stop = fpss_pkg::END_W'(req.start) + fpss_pkg::END_W'(len);
    if (stop > fpss_pkg::FLASH_TOP) stop = fpss_pkg::FLASH_TOP;
    // an erase walks whole sectors from the aligned start
    addr = req.erase ? fpss_pkg::END_W'(req.start & ~fpss_pkg::SECTOR_MASK)
                     : fpss_pkg::END_W'(req.start);
    if (len == 0) begin
      c.op_addr = addr[fpss_pkg::ADDR_W-1:0];
      c.byte_count = '0;
      c.last = 1'b1;
      chunk_q.push_back(c);
      return;
    end
    k = 0;
    fin = 1'b0;
    while (!fin) begin
      if (req.erase) begin
        cnt = fpss_pkg::CNT_W'(fpss_pkg::SECTOR_BYTES);
        nxt = addr + fpss_pkg::END_W'(fpss_pkg::SECTOR_BYTES);
      end else begin
        // a chunk stops at the page boundary or the end of the range
        room = fpss_pkg::END_W'(fpss_pkg::PAGE_BYTES)
             - (addr % fpss_pkg::END_W'(fpss_pkg::PAGE_BYTES));
        left = stop - addr;
        cnt = fpss_pkg::CNT_W'((room < left) ? room : left);
        nxt = addr + fpss_pkg::END_W'(cnt);
      end
      fin = (nxt >= stop) || (k + 1 >= fpss_pkg::MAX_RESULTS);
      c.op_addr = addr[fpss_pkg::ADDR_W-1:0];
      c.byte_count = cnt;
      c.last = fin;
      chunk_q.push_back(c);
      k++;
      addr = fpss_pkg::END_W'(nxt[fpss_pkg::ADDR_W-1:0]);
    end
  endfunction

  task automatic queue_req(logic erase, logic [fpss_pkg::ADDR_W-1:0] start,
                           logic [fpss_pkg::LEN_W-1:0] len);
    flash_req_t r;
    r.erase = erase;
    r.start = start;
    r.len = len;
    req_q.push_back(r);
  endtask

  // sender: bursts of offers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      // transaction on the input side: predict its results now
      if (push && !full) begin
        split_request(offered);
        n_accepted++;
      end
      // a held offer stays put until the block takes it
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (req_q.size() != 0) begin
          offered = req_q.pop_front();
          in_req_type <= offered.erase;
          in_start_addr <= offered.start;
          in_byte_len <= offered.len;
          push <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            // one burst in four runs straight into the next
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long hold-offs of the receiver, timed by their own cycle count
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_clock <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_clock == HOLD_AT_A || hold_clock == HOLD_AT_B) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // receiver: check each transaction against the oldest expectation, then
  // pick the next pop from the current stall pattern
  always @(posedge clk) begin
    chunk_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (chunk_q.size() == 0) begin
          $error("unexpected result: op_addr %h byte_count %0d last %b",
                 out_op_addr, out_byte_count, out_last);
          n_errors++;
        end else begin
          want = chunk_q.pop_front();
          if (out_op_addr !== want.op_addr) begin
            $error("op_addr: expected %h, got %h", want.op_addr, out_op_addr);
            n_errors++;
          end
          if (out_byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, out_byte_count);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            n_errors++;
          end
        end
      end
      // switch stall pattern when its random run length runs out
      if (drain_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 2));
        drain_left = $urandom_range(20, 120);
      end else begin
        drain_left--;
      end
      case (drain_mode)
        DRAIN_FREE:   pop <= (hold_left == 0);
        DRAIN_RANDOM: pop <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
        default:      pop <= (hold_left == 0) && (drain_left % 4 == 0);
      endcase
    end
  end

  // run guard
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("flash_page_and_sector_splitter regression: fail");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [fpss_pkg::ADDR_W-1:0] start;
    logic [fpss_pkg::LEN_W-1:0]  len;
    int                          pick;

    // zero length writes and erases, erase start aligned down
    queue_req(REQ_WRITE, 24'h000000, 14'd0);
    queue_req(REQ_ERASE, 24'h123456, 14'd0);
    queue_req(REQ_WRITE, 24'hFFFFFF, 14'd0);
    queue_req(REQ_ERASE, 24'hFFFFFF, 14'd0);
    // single byte and exact pages: no trailing empty chunk
    queue_req(REQ_WRITE, 24'h000000, 14'd1);
    queue_req(REQ_WRITE, 24'h000100, 14'd256);
    queue_req(REQ_WRITE, 24'h000200, 14'd512);
    // straddling a page boundary
    queue_req(REQ_WRITE, 24'h0000FF, 14'd2);
    // misaligned full length: the longest split
    queue_req(REQ_WRITE, 24'h000001, 14'd8192);
    // lengths above the maximum saturate, next to a long one below it
    queue_req(REQ_WRITE, 24'h00A5C3, 14'd16383);
    queue_req(REQ_WRITE, 24'h000080, 14'd8193);
    queue_req(REQ_WRITE, 24'hAAAAAA, 14'd5461);
    // clipping at the top of flash
    queue_req(REQ_WRITE, 24'hFFFFFF, 14'd1);
    queue_req(REQ_WRITE, 24'hFFFFF0, 14'd100);
    queue_req(REQ_WRITE, 24'hFFFF00, 14'd8192);
    // erase: one sector, two sectors, three sectors
    queue_req(REQ_ERASE, 24'h000000, 14'd1);
    queue_req(REQ_ERASE, 24'h000FFF, 14'd2);
    queue_req(REQ_ERASE, 24'h001000, 14'd4096);
    queue_req(REQ_ERASE, 24'h000800, 14'd8192);
    queue_req(REQ_ERASE, 24'h555555, 14'd10922);
    // erase clipped at the top
    queue_req(REQ_ERASE, 24'hFFF800, 14'd8192);
    queue_req(REQ_ERASE, 24'hFFFFFF, 14'd16383);

    // random requests, mostly short, with the top of flash and boundaries
    // hit often
    for (int i = 0; i < 350; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) start = fpss_pkg::ADDR_W'($urandom);
      else if (pick < 85) start = 24'hFFFFFF - fpss_pkg::ADDR_W'($urandom_range(0, 9000));
      else start = (fpss_pkg::ADDR_W'($urandom)
                    & ~fpss_pkg::ADDR_W'(fpss_pkg::PAGE_BYTES - 1))
                   + fpss_pkg::ADDR_W'($urandom_range(0, 2)) - fpss_pkg::ADDR_W'(1);
      pick = $urandom_range(0, 99);
      if (pick < 10) len = '0;
      else if (pick < 60) len = fpss_pkg::LEN_W'($urandom_range(1, 600));
      else if (pick < 85) len = fpss_pkg::LEN_W'($urandom_range(601, fpss_pkg::MAX_LEN));
      else if (pick < 95) len = fpss_pkg::LEN_W'($urandom_range(fpss_pkg::MAX_LEN + 1, 16383));
      else len = fpss_pkg::LEN_W'(fpss_pkg::PAGE_BYTES
                 * $urandom_range(1, fpss_pkg::MAX_LEN / fpss_pkg::PAGE_BYTES));
      queue_req($urandom_range(0, 1) ? REQ_ERASE : REQ_WRITE, start, len);
    end
    n_total = req_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every request taken, every result seen, then a quiet tail
    while (n_accepted < n_total) @(posedge clk);
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (n_errors == 0) begin
      $display("flash_page_and_sector_splitter regression: pass");
    end else begin
      $display("flash_page_and_sector_splitter regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
